/* design/tisc_pkg.sv */
// Shared constants for the table-interpolated sensor scaler: codes, register indexes, defaults.
package tisc_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 8;

  localparam int READING_W = 16;
  localparam int VALUE_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Item operations.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_INTERP   = 3'd0;
  localparam logic [2:0] ST_ABOVE    = 3'd1;
  localparam logic [2:0] ST_TOP      = 3'd2;
  localparam logic [2:0] ST_BOTTOM   = 3'd3;
  localparam logic [2:0] ST_UNSCALED = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Q_SHIFT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNIFY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_ENABLE = 3'd4;

endpackage

/* design/table_interpolated_sensor_scaler_top.sv */
// Top level of the table-interpolated sensor scaler: table store, sequencer, multiplier, divider.
//
// Load beats write one calibration point and leave the input free. A convert beat holds the
// input stalled until its result has been placed in the output register: an unscaled or
// above-threshold sample goes straight there, a top clamp multiplies and shifts, a bottom clamp
// first scans every segment in use, and an interpolated sample scans to its segment, multiplies,
// divides, adds, multiplies and shifts, scanning one segment per cycle through the single read
// port of the point store. The 16-step restoring divider sets most of the interpolation time;
// one 17 x 17 multiplier serves both the slope product and the magnify step. Configuration
// writes are always accepted and must only be made while the block is idle.
module table_interpolated_sensor_scaler_top #(
  parameter int TABLE_DEPTH = tisc_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                operation,
  input  logic [2:0]                          entry_index,
  input  logic [tisc_pkg::READING_W-1:0]      entry_reading,
  input  logic signed [tisc_pkg::VALUE_W-1:0] entry_value,
  input  logic [tisc_pkg::READING_W-1:0]      sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tisc_pkg::VALUE_W-1:0] scaled,
  output logic [2:0]                          status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tisc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tisc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tisc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH0, S_SCAN, S_MUL, S_DIV_SETUP, S_DIV, S_SUM, S_SHIFT, S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [15:0] threshold;
  logic [3:0]  table_count;
  logic [3:0]  q_shift;
  logic [9:0]  magnify;
  logic        scale_enable;

  // Point store.
  logic [READING_W-1:0]      point_readings [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] point_values   [TABLE_DEPTH];
  logic [READING_W-1:0]      rd_reading;
  logic signed [VALUE_W-1:0] rd_value;
  logic [AW-1:0]             rd_addr;

  // Datapath registers.
  logic [READING_W-1:0]      sample_r;
  logic [READING_W-1:0]      ra;
  logic signed [VALUE_W-1:0] ya;
  logic [AW-1:0]             seg;
  logic signed [16:0]        opa;
  logic signed [16:0]        opb;
  logic signed [33:0]        prod;
  logic signed [16:0]        span_r;
  logic [15:0]               div_p;
  logic [15:0]               div_q;
  logic [15:0]               div_d;
  logic                      div_neg;
  logic [3:0]                div_cnt;
  logic                      final_mul;
  logic [15:0]               res_data;
  logic [2:0]                res_status;

  logic                      accept;
  logic [CW-1:0]             n_use;
  logic                      hit;
  logic signed [16:0]        dx;
  logic signed [16:0]        span;
  logic signed [16:0]        dy;
  logic [33:0]               prod_mag;
  logic [16:0]               span_mag;
  logic [16:0]               trial;
  logic [16:0]               trial_diff;
  logic                      trial_ge;
  logic signed [16:0]        quot;
  logic signed [17:0]        y_sum;
  logic signed [33:0]        shifted;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= 16'hFFFF;
      table_count  <= 4'd2;
      q_shift      <= 4'd0;
      magnify      <= 10'd1;
      scale_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD:    threshold    <= cfg_data;
        REG_TABLE_COUNT:  table_count  <= cfg_data[3:0];
        REG_Q_SHIFT:      q_shift      <= cfg_data[3:0];
        REG_MAGNIFY:      magnify      <= cfg_data[9:0];
        REG_SCALE_ENABLE: scale_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Loads beyond the store are dropped; reads are registered.
  always_ff @(posedge clk) begin
    if (accept && operation == OP_LOAD && 32'(entry_index) < TABLE_DEPTH) begin
      point_readings[AW'(entry_index)] <= entry_reading;
      point_values[AW'(entry_index)]   <= entry_value;
    end
    rd_reading <= point_readings[rd_addr];
    rd_value   <= point_values[rd_addr];
  end

  always_comb begin
    case (state)
      S_FETCH0: rd_addr = AW'(1);
      S_SCAN:   rd_addr = AW'(32'(seg) + 32'd2);
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    if (table_count < 4'd2) begin
      n_use = CW'(2);
    end else if (32'(table_count) > TABLE_DEPTH) begin
      n_use = CW'(TABLE_DEPTH);
    end else begin
      n_use = CW'(table_count);
    end
  end

  // Segment test against the entry arriving from the store this cycle.
  always_comb begin
    hit  = (ra > rd_reading && sample_r <= ra && sample_r >= rd_reading) ||
           (ra < rd_reading && sample_r >= ra && sample_r <= rd_reading);
    dx   = $signed({1'b0, sample_r}) - $signed({1'b0, ra});
    span = $signed({1'b0, rd_reading}) - $signed({1'b0, ra});
    dy   = $signed({rd_value[15], rd_value}) - $signed({ya[15], ya});
  end

  always_comb begin
    prod_mag   = prod[33] ? 34'(-prod) : 34'(prod);
    span_mag   = span_r[16] ? 17'(-span_r) : 17'(span_r);
    trial      = {div_p, div_q[15]};
    trial_diff = trial - {1'b0, div_d};
    trial_ge   = (trial >= {1'b0, div_d});
    quot       = div_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    y_sum      = $signed({{2{ya[15]}}, ya}) + $signed({quot[16], quot});
    shifted    = prod >>> q_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && operation == OP_CONVERT) begin
            sample_r <= sample;
            if (!scale_enable) begin
              res_data   <= sample;
              res_status <= ST_UNSCALED;
              state      <= S_OUT;
            end else if (sample >= threshold) begin
              res_data   <= '0;
              res_status <= ST_ABOVE;
              state      <= S_OUT;
            end else begin
              state <= S_FETCH0;
            end
          end
        end
        S_FETCH0: begin
          if (sample_r >= rd_reading) begin
            opa        <= {rd_value[15], rd_value};
            opb        <= {7'd0, magnify};
            final_mul  <= 1'b1;
            res_status <= ST_TOP;
            state      <= S_MUL;
          end else begin
            ra    <= rd_reading;
            ya    <= rd_value;
            seg   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            opa        <= dy;
            opb        <= dx;
            span_r     <= span;
            final_mul  <= 1'b0;
            res_status <= ST_INTERP;
            state      <= S_MUL;
          end else if (32'(seg) + 32'd2 < 32'(n_use)) begin
            ra  <= rd_reading;
            ya  <= rd_value;
            seg <= AW'(32'(seg) + 32'd1);
          end else begin
            // No segment brackets the sample: clamp to the last point in use.
            opa        <= {rd_value[15], rd_value};
            opb        <= {7'd0, magnify};
            final_mul  <= 1'b1;
            res_status <= ST_BOTTOM;
            state      <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= opa * opb;
          state <= final_mul ? S_SHIFT : S_DIV_SETUP;
        end
        S_DIV_SETUP: begin
          // The quotient never exceeds the value step, so sixteen steps suffice.
          div_p   <= prod_mag[31:16];
          div_q   <= prod_mag[15:0];
          div_d   <= span_mag[15:0];
          div_neg <= prod[33] ^ span_r[16];
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_p   <= trial_ge ? trial_diff[15:0] : trial[15:0];
          div_q   <= {div_q[14:0], trial_ge};
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd15) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          opa       <= {y_sum[15], y_sum[15:0]};
          opb       <= {7'd0, magnify};
          final_mul <= 1'b1;
          state     <= S_MUL;
        end
        S_SHIFT: begin
          res_data <= shifted[15:0];
          state    <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            scaled    <= res_data;
            status    <= res_status;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/tisc_checker.sv */
// Port-level checker for the table-interpolated sensor scaler, bound to the top level.
module tisc_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              operation,
  input logic              out_valid,
  input logic              out_stall,
  input logic [15:0]       scaled,
  input logic [2:0]        status
);
  import tisc_pkg::*;

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(scaled) && $stable(status))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_INTERP || status == ST_ABOVE || status == ST_TOP ||
                   status == ST_BOTTOM || status == ST_UNSCALED))
    else $error("result status code out of range");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ABOVE |-> scaled == '0)
    else $error("above-threshold result is not zero");

  // An accepted convert beat raises the input stall.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && operation == OP_CONVERT |=> in_stall)
    else $error("input taken while a conversion is in progress");

  // A load beat never produces a result beat.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && operation == OP_LOAD && !out_valid |=> !out_valid)
    else $error("load beat produced a result");

endmodule

bind table_interpolated_sensor_scaler_top tisc_checker u_tisc_checker (.*);

/* tb/table_interpolated_sensor_scaler_top_tb.sv */
// Self-checking testbench for the table-interpolated sensor scaler with a built-in predictor.
module table_interpolated_sensor_scaler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tisc_pkg::*;

  localparam int TABLE_DEPTH   = TABLE_DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 66;

  typedef struct packed {
    logic               operation;
    logic [2:0]         entry_index;
    logic [15:0]        entry_reading;
    logic signed [15:0] entry_value;
    logic [15:0]        sample;
  } scaler_item_t;

  typedef struct packed {
    logic signed [15:0] scaled;
    logic [2:0]         status;
  } scaler_result_t;

  class calib_scoreboard;
    logic [15:0]        threshold;
    logic [3:0]         table_count;
    logic [3:0]         q_shift;
    logic [9:0]         magnify;
    logic               scale_enable;
    logic [15:0]        point_reading [TABLE_DEPTH];
    logic signed [15:0] point_value [TABLE_DEPTH];
    scaler_result_t     expected_results [$];
    int unsigned        failures;

    function new();
      threshold    = 16'hFFFF;
      table_count  = 4'd2;
      q_shift      = 4'd0;
      magnify      = 10'd1;
      scale_enable = 1'b0;
      failures     = 0;
      foreach (point_reading[i]) begin
        point_reading[i] = '0;
        point_value[i]   = '0;
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THRESHOLD:    threshold    = data;
        REG_TABLE_COUNT:  table_count  = data[3:0];
        REG_Q_SHIFT:      q_shift      = data[3:0];
        REG_MAGNIFY:      magnify      = data[9:0];
        REG_SCALE_ENABLE: scale_enable = data[0];
        default: ;
      endcase
    endfunction

    // The shift of a signed longint is arithmetic, so it rounds towards minus infinity.
    function logic signed [15:0] scale_point(longint v);
      longint m;
      m = (v * longint'(magnify)) >>> q_shift;
      return m[15:0];
    endfunction

    function void note_item(scaler_item_t it);
      scaler_result_t r;
      longint         ya, yb, dx, span, y;
      logic [15:0]    ra, rb;
      int             n;
      bit             found;
      if (it.operation == OP_LOAD) begin
        if (it.entry_index < TABLE_DEPTH) begin
          point_reading[it.entry_index] = it.entry_reading;
          point_value[it.entry_index]   = it.entry_value;
        end
        return;
      end
      if (!scale_enable) begin
        r = '{it.sample, ST_UNSCALED};
      end else if (it.sample >= threshold) begin
        r = '{16'sd0, ST_ABOVE};
      end else if (it.sample >= point_reading[0]) begin
        r = '{scale_point(point_value[0]), ST_TOP};
      end else begin
        n = (table_count < 2) ? 2 : (table_count > TABLE_DEPTH) ? TABLE_DEPTH : table_count;
        found = 1'b0;
        for (int i = 0; i + 1 < n; i++) begin
          ra = point_reading[i];
          rb = point_reading[i + 1];
          // A flat segment brackets nothing, so the span below is never zero.
          if (!found && ((ra > rb && it.sample <= ra && it.sample >= rb) ||
                         (ra < rb && it.sample >= ra && it.sample <= rb))) begin
            ya   = point_value[i];
            yb   = point_value[i + 1];
            dx   = longint'(it.sample) - longint'(ra);
            span = longint'(rb) - longint'(ra);
            y    = ya + ((yb - ya) * dx) / span;
            r     = '{scale_point(y), ST_INTERP};
            found = 1'b1;
          end
        end
        if (!found) r = '{scale_point(point_value[n - 1]), ST_BOTTOM};
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(scaler_result_t got);
      scaler_result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing pending: scaled %0d status %0d", got.scaled, got.status);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (got.scaled !== want.scaled) begin
        $error("scaled: expected %0d, got %0d", want.scaled, got.scaled);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst           = 1'b1;
  logic                   in_valid      = 1'b0;
  logic                   in_stall;
  logic                   operation     = OP_LOAD;
  logic [2:0]             entry_index   = '0;
  logic [15:0]            entry_reading = '0;
  logic signed [15:0]     entry_value   = '0;
  logic [15:0]            sample        = '0;
  logic                   out_valid;
  logic                   out_stall     = 1'b0;
  logic signed [15:0]     scaled;
  logic [2:0]             status;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;

  calib_scoreboard sb = new();
  bit              calm = 1'b0;
  int              quiet_cycles = 0;

  table_interpolated_sensor_scaler_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 20);
    end
  end

  // Input beats are noted before result beats are checked at each edge, though a result
  // never leaves on the same edge as its own input beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_item('{operation, entry_index, entry_reading, entry_value, sample});
      if (out_valid && !out_stall)
        sb.check_result('{scaled, status});
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("table_interpolated_sensor_scaler_top regression: fail");
    $finish;
  end

  task automatic push_item(logic op, logic [2:0] idx, logic [15:0] rd, logic [15:0] val,
                           logic [15:0] x);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    entry_index   <= idx;
    entry_reading <= rd;
    entry_value   <= val;
    sample        <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_point(logic [2:0] idx, logic [15:0] rd, logic [15:0] val);
    push_item(OP_LOAD, idx, rd, val, 16'($urandom));
  endtask

  task automatic convert(logic [15:0] x);
    push_item(OP_CONVERT, 3'($urandom), 16'($urandom), 16'($urandom), x);
  endtask

  // Stops the input stream and waits until every result is out and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // Unused upper bits of the narrow registers carry noise, which the block must ignore.
  task automatic configure(logic [15:0] thr, logic [3:0] cnt, logic [3:0] qs, logic [9:0] mag,
                           logic en);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_TABLE_COUNT, {12'($urandom), cnt});
    write_reg(REG_Q_SHIFT, {12'($urandom), qs});
    write_reg(REG_MAGNIFY, {6'($urandom), mag});
    write_reg(REG_SCALE_ENABLE, {15'($urandom), en});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly a falling table, sometimes with flat steps; now and then a scrambled one.
  task automatic load_table();
    logic [15:0] r;
    bit          scrambled;
    r = 16'($urandom_range(65535, 30000));
    scrambled = ($urandom_range(3) == 0);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      load_point(3'(i), scrambled ? 16'($urandom) : r, 16'($urandom));
      if ($urandom_range(7) != 0) r = r - 16'($urandom_range(r / 4));
    end
  endtask

  function automatic logic [15:0] pick_sample();
    int i;
    i = $urandom_range(TABLE_DEPTH - 2);
    case ($urandom_range(9))
      0, 1:    return 16'($urandom);
      2:       return sb.point_reading[$urandom_range(TABLE_DEPTH - 1)];
      3:       return sb.point_reading[0] + 16'($urandom_range(3));
      default: return 16'($urandom_range(sb.point_reading[i], sb.point_reading[i + 1]));
    endcase
  endfunction

  initial begin
    logic [15:0]        rd_init [TABLE_DEPTH];
    logic signed [15:0] val_init [TABLE_DEPTH];
    logic [15:0]        thr;
    logic [3:0]         cnt;
    logic [9:0]         mag;
    rd_init  = '{16'd60000, 16'd50000, 16'd40000, 16'd40000,
                 16'd30000, 16'd10000, 16'd5000, 16'd2000};
    val_init = '{16'sd100, 16'sd32767, -16'sd32768, 16'sd0,
                 16'sd1000, -16'sd500, 16'sd7, -16'sd1};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Scaling is off after reset, so the raw sample comes straight back.
    convert(16'h0000);
    convert(16'hFFFF);
    convert(16'h5AA5);
    for (int i = 0; i < TABLE_DEPTH; i++) load_point(3'(i), rd_init[i], val_init[i]);
    settle();

    configure(16'd65000, 4'd8, 4'd0, 10'd1, 1'b1);
    convert(16'd65535);
    convert(16'd65000);
    convert(16'd64999);
    convert(16'd55000);
    convert(16'd50000);
    convert(16'd35000);
    convert(16'd1000);
    settle();

    configure(16'd65535, 4'd3, 4'd15, 10'd1023, 1'b1);
    convert(16'd55000);
    convert(16'd45000);
    convert(16'd20000);
    settle();

    // A count below two is taken as two; a zero multiplier wipes every result.
    configure(16'd65535, 4'd0, 4'd0, 10'd0, 1'b1);
    convert(16'd55000);
    convert(16'd62000);
    convert(16'd45000);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      calm = (phase == 4);
      case ($urandom_range(7))
        0:       thr = 16'd0;
        1:       thr = 16'hFFFF;
        default: thr = 16'($urandom_range(65535, 40000));
      endcase
      case ($urandom_range(7))
        0:       cnt = 4'd15;
        1:       cnt = 4'($urandom);
        default: cnt = 4'($urandom_range(TABLE_DEPTH, 2));
      endcase
      case ($urandom_range(7))
        0:       mag = 10'd0;
        1:       mag = 10'd1023;
        default: mag = 10'($urandom_range(1023, 1));
      endcase
      configure(thr, cnt, 4'($urandom), mag, $urandom_range(9) != 0);
      load_table();
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(9) == 0)
          load_point(3'($urandom), 16'($urandom), 16'($urandom));
        else
          convert(pick_sample());
      end
      settle();
    end

    if (sb.expected_results.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_results.size());
      sb.failures++;
    end
    if (sb.failures == 0)
      $display("table_interpolated_sensor_scaler_top regression: pass");
    else
      $display("table_interpolated_sensor_scaler_top regression: fail");
    $finish;
  end

endmodule
